// ===== hdl/rgb_to_hsl_converter_assert.svh =====
// ----------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Shared property macros for the converter's concurrent checks. Each macro
// expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBHSL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsl_converter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGBHSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsl_converter: next-cycle check failed");

`endif

// ===== hdl/rgbhsl_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Payload types, divider request and response types, and fixed constants.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int NUM_W = 18;
  localparam int DEN_W = 9;
  localparam int QUO_W = 9;

  localparam logic [2:0] SECTOR_RED   = 3'd0;
  localparam logic [2:0] SECTOR_GREEN = 3'd2;
  localparam logic [2:0] SECTOR_BLUE  = 3'd4;
  localparam logic [2:0] SECTOR_WRAP  = 3'd6;

  localparam logic [8:0] HUE_FULL   = 9'd360;
  localparam logic [8:0] FULL_SCALE = 9'd255;
  localparam logic [8:0] SUM_MAX    = 9'd510;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [8:0] lightness_sum;
    logic [7:0] saturation_frac;
  } hsl_t;

  typedef struct packed {
    logic [NUM_W-1:0] hue_num;
    logic [DEN_W-1:0] hue_den;
    logic [NUM_W-1:0] sat_num;
    logic [DEN_W-1:0] sat_den;
    logic [8:0]       sum;
    logic             grey;
  } div_req_t;

  typedef struct packed {
    logic [QUO_W-1:0] hue_quo;
    logic [QUO_W-1:0] sat_quo;
    logic [8:0]       sum;
    logic             grey;
  } div_rsp_t;

endpackage

// ===== hdl/rgbhsl_div.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL dual divider pipeline
// Two restoring dividers in lockstep, one quotient bit per register stage,
// with the sideband fields and a valid bit carried along each stage.
// ----------------------------------------------------------------------------
module rgbhsl_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                req_valid,
  input  rgbhsl_pkg::div_req_t req,
  output logic                rsp_valid,
  output rgbhsl_pkg::div_rsp_t rsp
);

  localparam int STAGES = rgbhsl_pkg::QUO_W;

  typedef struct packed {
    logic [rgbhsl_pkg::NUM_W-1:0] hue_rem;
    logic [rgbhsl_pkg::DEN_W-1:0] hue_den;
    logic [rgbhsl_pkg::QUO_W-1:0] hue_quo;
    logic [rgbhsl_pkg::NUM_W-1:0] sat_rem;
    logic [rgbhsl_pkg::DEN_W-1:0] sat_den;
    logic [rgbhsl_pkg::QUO_W-1:0] sat_quo;
    logic [8:0]                   sum;
    logic                         grey;
  } stage_t;

  stage_t             stage_r   [0:STAGES-1];
  stage_t             stage_nxt [0:STAGES-1];
  stage_t             stage_src [0:STAGES-1];
  logic [STAGES-1:0]  valid_r;
  logic [STAGES-1:0]  valid_src;

  assign stage_src[0].hue_rem = req.hue_num;
  assign stage_src[0].hue_den = req.hue_den;
  assign stage_src[0].hue_quo = '0;
  assign stage_src[0].sat_rem = req.sat_num;
  assign stage_src[0].sat_den = req.sat_den;
  assign stage_src[0].sat_quo = '0;
  assign stage_src[0].sum     = req.sum;
  assign stage_src[0].grey    = req.grey;
  assign valid_src[0]         = req_valid;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int SH = STAGES - 1 - s;

    logic [rgbhsl_pkg::NUM_W-1:0] hue_sub;
    logic [rgbhsl_pkg::NUM_W-1:0] sat_sub;
    logic                         hue_ge;
    logic                         sat_ge;

    if (s > 0) begin : g_link
      assign stage_src[s] = stage_r[s-1];
      assign valid_src[s] = valid_r[s-1];
    end

    assign hue_sub = rgbhsl_pkg::NUM_W'(stage_src[s].hue_den) << SH;
    assign sat_sub = rgbhsl_pkg::NUM_W'(stage_src[s].sat_den) << SH;
    assign hue_ge  = stage_src[s].hue_rem >= hue_sub;
    assign sat_ge  = stage_src[s].sat_rem >= sat_sub;

    always_comb begin
      stage_nxt[s] = stage_src[s];
      stage_nxt[s].hue_quo[SH] = hue_ge;
      stage_nxt[s].sat_quo[SH] = sat_ge;
      if (hue_ge) begin
        stage_nxt[s].hue_rem = stage_src[s].hue_rem - hue_sub;
      end
      if (sat_ge) begin
        stage_nxt[s].sat_rem = stage_src[s].sat_rem - sat_sub;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_src[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[s] <= stage_nxt[s];
      end
    end
  end

  assign rsp_valid   = valid_r[STAGES-1];
  assign rsp.hue_quo = stage_r[STAGES-1].hue_quo;
  assign rsp.sat_quo = stage_r[STAGES-1].sat_quo;
  assign rsp.sum     = stage_r[STAGES-1].sum;
  assign rsp.grey    = stage_r[STAGES-1].grey;

endmodule

// ===== hdl/rgb_to_hsl_converter.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per clock, unless the output is held, into hue in
// degrees, the sum of the largest and smallest components, and saturation scaled to 255.
// ----------------------------------------------------------------------------
// Usage: a pixel is transferred on the input channel when in_valid is high
// and in_stall is low; a result is transferred on the output channel when
// out_valid is high and out_stall is low. Each pixel gives exactly one result,
// in order.
// From input transfer to out_valid, three stages find the extremes and build
// the dividends, nine stages resolve one quotient bit each for hue and
// saturation, and the output register wraps the hue and clamps saturation.
// Throughput is one pixel per cycle while the output is not held; it is set by
// the divider pipeline, which takes a new pair of divisions in every stage each enabled cycle.
// Reset clears every valid bit; no result is pending afterward.
// When out_valid is high and out_stall is high, the whole pipeline holds and
// in_stall is raised in the same cycle; no pixel is lost or repeated.
// Empty stages still advance whenever the output is not held.
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_converter_assert.svh"

module rgb_to_hsl_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rgbhsl_pkg::pixel_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rgbhsl_pkg::hsl_t   out_data
);

  logic en;

  logic [7:0]        mx;
  logic [7:0]        mn;
  logic [2:0]        sector;
  logic signed [8:0] tilt;

  logic              v1_r;
  logic [7:0]        d1_r;
  logic [8:0]        sum1_r;
  logic [2:0]        k1_r;
  logic signed [8:0] t1_r;

  logic [10:0]        kd;
  logic signed [11:0] m_s;
  logic [8:0]         den;

  logic              v2_r;
  logic [10:0]       m2_r;
  logic [7:0]        d2_r;
  logic [8:0]        sum2_r;
  logic [8:0]        den2_r;

  logic                 v3_r;
  rgbhsl_pkg::div_req_t req3_nxt;
  rgbhsl_pkg::div_req_t req3_r;

  logic                 div_valid;
  rgbhsl_pkg::div_rsp_t div_rsp;

  logic              out_valid_r;
  rgbhsl_pkg::hsl_t  out_data_r;
  rgbhsl_pkg::hsl_t  out_data_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = out_valid_r && out_stall;

  always_comb begin
    mx = in_data.red;
    mn = in_data.red;
    if (in_data.green > mx) begin
      mx = in_data.green;
    end
    if (in_data.blue > mx) begin
      mx = in_data.blue;
    end
    if (in_data.green < mn) begin
      mn = in_data.green;
    end
    if (in_data.blue < mn) begin
      mn = in_data.blue;
    end
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      sector = (in_data.green >= in_data.blue) ? rgbhsl_pkg::SECTOR_RED
                                               : rgbhsl_pkg::SECTOR_WRAP;
      tilt   = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
    end else if (in_data.green >= in_data.blue) begin
      sector = rgbhsl_pkg::SECTOR_GREEN;
      tilt   = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
    end else begin
      sector = rgbhsl_pkg::SECTOR_BLUE;
      tilt   = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= mx - mn;
      sum1_r <= {1'b0, mx} + {1'b0, mn};
      k1_r   <= sector;
      t1_r   <= tilt;
    end
  end

  always_comb begin
    case (k1_r)
      rgbhsl_pkg::SECTOR_RED:   kd = '0;
      rgbhsl_pkg::SECTOR_GREEN: kd = {2'b00, d1_r, 1'b0};
      rgbhsl_pkg::SECTOR_BLUE:  kd = {1'b0, d1_r, 2'b00};
      rgbhsl_pkg::SECTOR_WRAP:  kd = {1'b0, d1_r, 2'b00} + {2'b00, d1_r, 1'b0};
      default:                  kd = '0;
    endcase
    m_s = $signed({1'b0, kd}) + 12'(t1_r);
    den = (sum1_r <= rgbhsl_pkg::FULL_SCALE) ? sum1_r : (rgbhsl_pkg::SUM_MAX - sum1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r   <= m_s[10:0];
      d2_r   <= d1_r;
      sum2_r <= sum1_r;
      den2_r <= den;
    end
  end

  always_comb begin
    req3_nxt.hue_num = ({m2_r, 7'd0} - {4'd0, m2_r, 3'd0}) + 18'(d2_r);
    req3_nxt.hue_den = {d2_r, 1'b0};
    req3_nxt.sat_num = ({1'b0, d2_r, 9'd0} - {9'd0, d2_r, 1'b0}) + 18'(den2_r);
    req3_nxt.sat_den = {den2_r[7:0], 1'b0};
    req3_nxt.sum     = sum2_r;
    req3_nxt.grey    = (d2_r == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req3_r <= req3_nxt;
    end
  end

  rgbhsl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req_valid (v3_r),
    .req       (req3_r),
    .rsp_valid (div_valid),
    .rsp       (div_rsp)
  );

  always_comb begin
    out_data_nxt.lightness_sum = div_rsp.sum;
    if (div_rsp.grey || div_rsp.hue_quo >= rgbhsl_pkg::HUE_FULL) begin
      out_data_nxt.hue_degrees = '0;
    end else begin
      out_data_nxt.hue_degrees = div_rsp.hue_quo;
    end
    if (div_rsp.grey) begin
      out_data_nxt.saturation_frac = '0;
    end else if (div_rsp.sat_quo > rgbhsl_pkg::FULL_SCALE) begin
      out_data_nxt.saturation_frac = rgbhsl_pkg::FULL_SCALE[7:0];
    end else begin
      out_data_nxt.saturation_frac = div_rsp.sat_quo[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RGBHSL_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_r)
  `RGBHSL_ASSERT_SAME(a_hue_range, out_valid_r, out_data_r.hue_degrees < rgbhsl_pkg::HUE_FULL)
  `RGBHSL_ASSERT_SAME(a_black_grey, out_valid_r && out_data_r.lightness_sum == 9'd0,
                      out_data_r.saturation_frac == 8'd0 && out_data_r.hue_degrees == 9'd0)
  `RGBHSL_ASSERT_SAME(a_white_grey,
                      out_valid_r && out_data_r.lightness_sum == rgbhsl_pkg::SUM_MAX,
                      out_data_r.saturation_frac == 8'd0)

endmodule

// ===== bench/hsl_result_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSL result monitor
// Watches both channels of the RGB to HSL converter. Every accepted pixel is
// converted with exact integer arithmetic into the HSL triple it must give,
// and every accepted result is compared field by field with the oldest
// pending triple. Counts of mismatches, pending triples and checked results
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module hsl_result_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rgbhsl_pkg::pixel_t in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rgbhsl_pkg::hsl_t   out_data,
  output int                 mismatch_count,
  output int                 pending_count,
  output int                 checked_count
);

  localparam int unsigned HUE_STEP = 60;

  rgbhsl_pkg::hsl_t expected_hsl[$];

  function automatic rgbhsl_pkg::hsl_t convert_pixel(input rgbhsl_pkg::pixel_t px);
    int unsigned r, g, b, mx, mn, d, sum, num, hue, sat, den;
    rgbhsl_pkg::hsl_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    hue = 0;
    sat = 0;
    num = 0;
    if (d != 0) begin
      if (mx == r) begin
        if (g >= b) num = HUE_STEP * (g - b);
        else num = rgbhsl_pkg::HUE_FULL * d - HUE_STEP * (b - g);
      end else if (mx == g) begin
        if (b >= r) num = 2 * HUE_STEP * d + HUE_STEP * (b - r);
        else num = 2 * HUE_STEP * d - HUE_STEP * (r - b);
      end else begin
        if (r >= g) num = 4 * HUE_STEP * d + HUE_STEP * (r - g);
        else num = 4 * HUE_STEP * d - HUE_STEP * (g - r);
      end
      hue = (2 * num + d) / (2 * d);
      if (hue >= rgbhsl_pkg::HUE_FULL) hue = 0;
      den = (sum <= rgbhsl_pkg::FULL_SCALE) ? sum : (rgbhsl_pkg::SUM_MAX - sum);
      sat = (2 * rgbhsl_pkg::FULL_SCALE * d + den) / (2 * den);
      if (sat > rgbhsl_pkg::FULL_SCALE) sat = rgbhsl_pkg::FULL_SCALE;
    end
    res.hue_degrees = hue[8:0];
    res.lightness_sum = sum[8:0];
    res.saturation_frac = sat[7:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rgbhsl_pkg::hsl_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      expected_hsl.delete();
      mismatch_count <= 0;
      pending_count <= 0;
      checked_count <= 0;
    end else begin
      if (in_valid && !in_stall) expected_hsl.push_back(convert_pixel(in_data));
      if (out_valid && !out_stall) begin
        if (expected_hsl.size() == 0) begin
          $error("unexpected result transfer: hue_degrees %0d, lightness_sum %0d, %s %0d",
                 out_data.hue_degrees, out_data.lightness_sum, "saturation_frac",
                 out_data.saturation_frac);
          errs = errs + 1;
        end else begin
          want = expected_hsl.pop_front();
          checked_count <= checked_count + 1;
          if (want.hue_degrees !== out_data.hue_degrees) begin
            $error("hue_degrees: expected %0d, actual %0d",
                   want.hue_degrees, out_data.hue_degrees);
            errs = errs + 1;
          end
          if (want.lightness_sum !== out_data.lightness_sum) begin
            $error("lightness_sum: expected %0d, actual %0d",
                   want.lightness_sum, out_data.lightness_sum);
            errs = errs + 1;
          end
          if (want.saturation_frac !== out_data.saturation_frac) begin
            $error("saturation_frac: expected %0d, actual %0d",
                   want.saturation_frac, out_data.saturation_frac);
            errs = errs + 1;
          end
        end
      end
      mismatch_count <= mismatch_count + errs;
      pending_count <= expected_hsl.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Sends directed corner pixels and then random pixels through the converter
// under four handshake phases: free flow, a sparse sender, a stalling
// receiver, and both at once. The result monitor predicts and checks every
// result; this top makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PHASE_ITEMS = 150;
  localparam int DRAIN_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rgbhsl_pkg::pixel_t in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rgbhsl_pkg::hsl_t   out_data;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int gap_pct = 0;
  int stall_pct = 0;

  always #1 clk = ~clk;

  rgb_to_hsl_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  hsl_result_monitor result_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Called just after a rising edge; returns just after the edge of the transfer.
  task automatic send_pixel(input rgbhsl_pkg::pixel_t px);
    bit taken;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  function automatic rgbhsl_pkg::pixel_t random_pixel();
    rgbhsl_pkg::pixel_t px;
    logic [7:0] hi, lo;
    px = 24'($urandom);
    hi = 8'($urandom_range(255));
    lo = 8'($urandom_range(hi));
    case ($urandom_range(9))
      0: px = '{hi, hi, hi};
      1: begin
        case ($urandom_range(2))
          0: px = '{hi, hi, lo};
          1: px = '{hi, lo, hi};
          default: px = '{lo, hi, hi};
        endcase
      end
      2: begin
        if ($urandom_range(1)) px.red = $urandom_range(1) ? 8'd255 : 8'd0;
        if ($urandom_range(1)) px.green = $urandom_range(1) ? 8'd255 : 8'd0;
        if ($urandom_range(1)) px.blue = $urandom_range(1) ? 8'd255 : 8'd0;
      end
      default: ;
    endcase
    return px;
  endfunction

  initial begin
    rgbhsl_pkg::pixel_t corner_pixels[$];
    corner_pixels = '{
      '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
      '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255},
      '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255},
      '{8'd255, 8'd0, 8'd1}, '{8'd200, 8'd10, 8'd11}, '{8'd200, 8'd10, 8'd100},
      '{8'd200, 8'd200, 8'd50}, '{8'd50, 8'd200, 8'd200}, '{8'd200, 8'd50, 8'd200},
      '{8'd1, 8'd0, 8'd0}, '{8'd254, 8'd255, 8'd255}, '{8'd255, 8'd254, 8'd254},
      '{8'd128, 8'd64, 8'd32}, '{8'd30, 8'd90, 8'd150}, '{8'd170, 8'd85, 8'd0},
      '{8'd3, 8'd1, 8'd2}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 65; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 65; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      repeat (PHASE_ITEMS) send_pixel(random_pixel());
      wait_for_results();
    end

    gap_pct = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: grey, tie, hue wrap and saturation clamp corners,",
             checked_count);
    $display("then random pixels under free flow, sparse input, output stalls and both.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rgbhsl_pkg.sv
hdl/rgbhsl_div.sv
hdl/rgb_to_hsl_converter.sv
bench/hsl_result_monitor.sv
bench/testbench.sv
